@@ design/nearest_scale_heatmap_colorizer_top_assert.svh @@
// assertion macros shared by the colorizer rtl
`ifndef NEAREST_SCALE_HEATMAP_COLORIZER_TOP_ASSERT_SVH
`define NEAREST_SCALE_HEATMAP_COLORIZER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NSH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define NSH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/nsh_pkg.sv @@
`timescale 1ns / 1ps

package nsh_pkg;

	// fixed field widths
	localparam int SRC_DIM_W  = 7;
	localparam int OUT_DIM_W  = 11;
	localparam int COORD_W    = 10;
	localparam int LOAD_IDX_W = 12;
	localparam int LOAD_VAL_W = 10;
	localparam int CH_W       = 10;
	localparam int SRC_IDX_W  = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// derived datapath widths
	localparam int PROD_W     = COORD_W + SRC_DIM_W;
	localparam int QUOT_W     = SRC_DIM_W;
	localparam int IDX_FULL_W = 2 * SRC_DIM_W;
	localparam int SAMPLE_MAX_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEAT_MODE  = 3'd4;

	// opcodes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_RENDER = 1'b1;

	// heatmap band edges
	localparam logic [SAMPLE_MAX_W-1:0] BAND_1 = 16'd255;
	localparam logic [SAMPLE_MAX_W-1:0] BAND_2 = 16'd510;
	localparam logic [SAMPLE_MAX_W-1:0] BAND_3 = 16'd765;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// grayscale replication or piecewise heatmap
	function automatic rgb_t colorize(input logic [SAMPLE_MAX_W-1:0] v, input logic heat);
		rgb_t c;
		logic [SAMPLE_MAX_W-1:0] d;
		c = '0;
		d = '0;
		if (!heat) begin
			c.red   = v[CH_W-1:0];
			c.green = v[CH_W-1:0];
			c.blue  = v[CH_W-1:0];
		end else if (v < BAND_1) begin
			c.blue = v[CH_W-1:0];
		end else if (v < BAND_2) begin
			d = v - BAND_1;
			c.green = d[CH_W-1:0];
			d = BAND_2 - v;
			c.blue = d[CH_W-1:0];
		end else if (v < BAND_3) begin
			d = v - BAND_2;
			c.red = d[CH_W-1:0];
			d = BAND_3 - v;
			c.green = d[CH_W-1:0];
		end else begin
			d = v - BAND_3;
			if (d > BAND_1) begin
				d = BAND_1;
			end
			c.red   = BAND_1[CH_W-1:0];
			c.green = d[CH_W-1:0];
			c.blue  = d[CH_W-1:0];
		end
		return c;
	endfunction

endpackage

@@ design/nsh_div.sv @@
`timescale 1ns / 1ps

// restoring radix-2 divider, one quotient bit per cycle
// dividend must be below divisor * 2**QUOT_W
module nsh_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nsh_pkg::div_ctl_t                 ctl,
	input  logic [nsh_pkg::PROD_W-1:0]        dividend,
	input  logic [nsh_pkg::OUT_DIM_W-1:0]     divisor,
	output nsh_pkg::div_sts_t                 sts,
	output logic [nsh_pkg::QUOT_W-1:0]        quotient
);

	localparam int CNT_W = $clog2(nsh_pkg::QUOT_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [nsh_pkg::OUT_DIM_W-1:0] rem_q;
	logic [nsh_pkg::OUT_DIM_W-1:0] dvs_q;
	logic [nsh_pkg::QUOT_W-1:0]    shf_q;

	logic [nsh_pkg::OUT_DIM_W:0]   trial;
	logic                          fits;
	logic [nsh_pkg::OUT_DIM_W:0]   diff;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, shf_q[nsh_pkg::QUOT_W-1]};
		fits  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(nsh_pkg::QUOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= nsh_pkg::OUT_DIM_W'(dividend[nsh_pkg::PROD_W-1:nsh_pkg::QUOT_W]);
			shf_q <= dividend[nsh_pkg::QUOT_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[nsh_pkg::OUT_DIM_W-1:0] : trial[nsh_pkg::OUT_DIM_W-1:0];
			shf_q <= {shf_q[nsh_pkg::QUOT_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = shf_q;

endmodule

@@ design/nsh_store.sv @@
`timescale 1ns / 1ps

// sample memory, one write and one registered read per cycle
module nsh_store #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12,
	parameter int DATA_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/nearest_scale_heatmap_colorizer_top.sv @@
`timescale 1ns / 1ps

// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------------
// input    | in_valid / in_ready    | opcode, load_index, load_value, out_row, out_col
// output   | out_valid / out_ready  | red, green, blue, source_index
// config   | cfg_write              | cfg_index, cfg_data
//
// a load with an index inside the memory is written in the cycle it is taken; a render runs two 7-step divisions
// on the one shared radix-2 divider plus the multiply, index, read and colormap steps
// in_ready is high only while the sequencer is idle; a finished pixel waits in the
// output register and the next item can be taken meanwhile
// a render stalls in its last step until the output register is free
// arst_n clears control and configuration; the sample memory is not cleared
`include "nearest_scale_heatmap_colorizer_top_assert.svh"

module nearest_scale_heatmap_colorizer_top #(
	parameter int SRC_SIDE    = 64,
	parameter int OUT_SIDE    = 1024,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [nsh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nsh_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [nsh_pkg::LOAD_IDX_W-1:0]    load_index,
	input  logic [nsh_pkg::LOAD_VAL_W-1:0]    load_value,
	input  logic [nsh_pkg::COORD_W-1:0]       out_row,
	input  logic [nsh_pkg::COORD_W-1:0]       out_col,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [nsh_pkg::CH_W-1:0]          red,
	output logic [nsh_pkg::CH_W-1:0]          green,
	output logic [nsh_pkg::CH_W-1:0]          blue,
	output logic [nsh_pkg::SRC_IDX_W-1:0]     source_index
);

	localparam int DEPTH  = SRC_SIDE * SRC_SIDE;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL_R  = 4'd1;
	localparam logic [3:0] S_DIV_R  = 4'd2;
	localparam logic [3:0] S_WAIT_R = 4'd3;
	localparam logic [3:0] S_DIV_C  = 4'd4;
	localparam logic [3:0] S_WAIT_C = 4'd5;
	localparam logic [3:0] S_INDEX  = 4'd6;
	localparam logic [3:0] S_READ   = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;

	logic [3:0] state_q;

	// configuration registers
	logic [nsh_pkg::SRC_DIM_W-1:0] src_width_q;
	logic [nsh_pkg::SRC_DIM_W-1:0] src_height_q;
	logic [nsh_pkg::OUT_DIM_W-1:0] out_width_q;
	logic [nsh_pkg::OUT_DIM_W-1:0] out_height_q;
	logic                          heat_mode_q;

	// clamped dimensions
	logic [nsh_pkg::SRC_DIM_W-1:0] sw;
	logic [nsh_pkg::SRC_DIM_W-1:0] sh;
	logic [nsh_pkg::OUT_DIM_W-1:0] ow;
	logic [nsh_pkg::OUT_DIM_W-1:0] oh;
	logic [nsh_pkg::OUT_DIM_W-1:0] ow_last;
	logic [nsh_pkg::OUT_DIM_W-1:0] oh_last;

	// per-pixel working registers
	logic [nsh_pkg::COORD_W-1:0]    row_q;
	logic [nsh_pkg::COORD_W-1:0]    col_q;
	logic [nsh_pkg::PROD_W-1:0]     prod_q;
	logic [nsh_pkg::QUOT_W-1:0]     sr_q;
	logic [nsh_pkg::QUOT_W-1:0]     sc_q;
	logic [nsh_pkg::IDX_FULL_W-1:0] idx_q;

	// output register
	logic                          out_valid_q;
	logic [nsh_pkg::CH_W-1:0]      red_q;
	logic [nsh_pkg::CH_W-1:0]      green_q;
	logic [nsh_pkg::CH_W-1:0]      blue_q;
	logic [nsh_pkg::SRC_IDX_W-1:0] source_index_q;

	nsh_pkg::div_ctl_t             div_ctl;
	nsh_pkg::div_sts_t             div_sts;
	logic [nsh_pkg::OUT_DIM_W-1:0] div_divisor;
	logic [nsh_pkg::QUOT_W-1:0]    div_quot;

	logic                   in_xfer;
	logic                   load_ok;
	logic                   mem_we;
	logic                   mem_re;
	logic [SAMPLE_BITS-1:0] mem_rdata;
	logic                   out_load;
	nsh_pkg::rgb_t          pixel;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= nsh_pkg::SRC_DIM_W'(64);
			src_height_q <= nsh_pkg::SRC_DIM_W'(64);
			out_width_q  <= nsh_pkg::OUT_DIM_W'(64);
			out_height_q <= nsh_pkg::OUT_DIM_W'(64);
			heat_mode_q  <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				nsh_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data[nsh_pkg::SRC_DIM_W-1:0];
				nsh_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data[nsh_pkg::SRC_DIM_W-1:0];
				nsh_pkg::REG_OUT_WIDTH:  out_width_q  <= cfg_data;
				nsh_pkg::REG_OUT_HEIGHT: out_height_q <= cfg_data;
				nsh_pkg::REG_HEAT_MODE:  heat_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp dimensions into their legal ranges
	always_comb begin
		sw = (src_width_q == '0) ? nsh_pkg::SRC_DIM_W'(1) :
			(32'(src_width_q) > SRC_SIDE) ? nsh_pkg::SRC_DIM_W'(SRC_SIDE) : src_width_q;
		sh = (src_height_q == '0) ? nsh_pkg::SRC_DIM_W'(1) :
			(32'(src_height_q) > SRC_SIDE) ? nsh_pkg::SRC_DIM_W'(SRC_SIDE) : src_height_q;
		ow = (out_width_q == '0) ? nsh_pkg::OUT_DIM_W'(1) :
			(32'(out_width_q) > OUT_SIDE) ? nsh_pkg::OUT_DIM_W'(OUT_SIDE) : out_width_q;
		oh = (out_height_q == '0) ? nsh_pkg::OUT_DIM_W'(1) :
			(32'(out_height_q) > OUT_SIDE) ? nsh_pkg::OUT_DIM_W'(OUT_SIDE) : out_height_q;
		ow_last = ow - 1'b1;
		oh_last = oh - 1'b1;
	end

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign load_ok  = 32'(load_index) < DEPTH;
	assign mem_we   = in_xfer && (opcode == nsh_pkg::OP_LOAD) && load_ok;
	assign mem_re   = (state_q == S_READ);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// divider hookup: row pass divides by the output height, column pass by the width
	assign div_ctl.start = (state_q == S_DIV_R) || (state_q == S_DIV_C);
	assign div_divisor   = (state_q == S_DIV_C) ? ow : oh;

	nsh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (prod_q),
		.divisor  (div_divisor),
		.sts      (div_sts),
		.quotient (div_quot)
	);

	nsh_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (SAMPLE_BITS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ADDR_W'(load_index)),
		.wdata (SAMPLE_BITS'(load_value)),
		.re    (mem_re),
		.raddr (ADDR_W'(idx_q)),
		.rdata (mem_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer && (opcode == nsh_pkg::OP_RENDER)) begin
						state_q <= S_MUL_R;
					end
				end
				S_MUL_R:  state_q <= S_DIV_R;
				S_DIV_R:  state_q <= S_WAIT_R;
				S_WAIT_R: begin
					if (div_sts.done) begin
						state_q <= S_DIV_C;
					end
				end
				S_DIV_C:  state_q <= S_WAIT_C;
				S_WAIT_C: begin
					if (div_sts.done) begin
						state_q <= S_INDEX;
					end
				end
				S_INDEX:  state_q <= S_READ;
				S_READ:   state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// coordinate capture, products and flat index
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			row_q <= ({1'b0, out_row} > oh_last) ? oh_last[nsh_pkg::COORD_W-1:0] : out_row;
			col_q <= ({1'b0, out_col} > ow_last) ? ow_last[nsh_pkg::COORD_W-1:0] : out_col;
		end
		if (state_q == S_MUL_R) begin
			prod_q <= nsh_pkg::PROD_W'(row_q) * nsh_pkg::PROD_W'(sh);
		end
		if ((state_q == S_WAIT_R) && div_sts.done) begin
			sr_q   <= div_quot;
			prod_q <= nsh_pkg::PROD_W'(col_q) * nsh_pkg::PROD_W'(sw);
		end
		if ((state_q == S_WAIT_C) && div_sts.done) begin
			sc_q <= div_quot;
		end
		if (state_q == S_INDEX) begin
			idx_q <= nsh_pkg::IDX_FULL_W'(sr_q) * nsh_pkg::IDX_FULL_W'(sw)
				+ nsh_pkg::IDX_FULL_W'(sc_q);
		end
	end

	// colormap of the fetched sample
	assign pixel = nsh_pkg::colorize(nsh_pkg::SAMPLE_MAX_W'(mem_rdata), heat_mode_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			red_q          <= pixel.red;
			green_q        <= pixel.green;
			blue_q         <= pixel.blue;
			source_index_q <= nsh_pkg::SRC_IDX_W'(idx_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign source_index = source_index_q;

	// checks
	`NSH_ASSERT_IMP(a_div_start_idle, clk, arst_n, div_ctl.start, !div_sts.busy, "divider restarted while busy")
	`NSH_ASSERT_IMP(a_div_done_waited, clk, arst_n, div_sts.done, (state_q == S_WAIT_R) || (state_q == S_WAIT_C), "divider finished outside a wait step")
	`NSH_ASSERT_IMP(a_index_in_store, clk, arst_n, state_q == S_READ, 32'(idx_q) < DEPTH, "source index beyond the sample store")
	`NSH_ASSERT_NXT(a_result_held, clk, arst_n, (state_q == S_OUT) && out_valid_q && !out_ready, state_q == S_OUT, "pending pixel dropped while output full")

endmodule
